/* hw/rtl/fdsu_pkg.sv */
// ----------------------------------------------------------------------------
// fdsu_pkg: shared definitions for the Forth data-stack unit
// Word codes, error codes, operand counts and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsu_pkg;

    localparam int DW              = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MEM_DEPTH_DEF   = 256;
    localparam int CELL_BYTES      = 8;

    localparam logic [4:0] K_LIT   = 5'd0;
    localparam logic [4:0] K_ADD   = 5'd1;
    localparam logic [4:0] K_SUB   = 5'd2;
    localparam logic [4:0] K_MUL   = 5'd3;
    localparam logic [4:0] K_DIV   = 5'd4;
    localparam logic [4:0] K_DOT   = 5'd5;
    localparam logic [4:0] K_DUP   = 5'd6;
    localparam logic [4:0] K_DROP  = 5'd7;
    localparam logic [4:0] K_SWAP  = 5'd8;
    localparam logic [4:0] K_TUCK  = 5'd9;
    localparam logic [4:0] K_OVER  = 5'd10;
    localparam logic [4:0] K_ROT   = 5'd11;
    localparam logic [4:0] K_2DUP  = 5'd12;
    localparam logic [4:0] K_2DROP = 5'd13;
    localparam logic [4:0] K_STORE = 5'd14;
    localparam logic [4:0] K_FETCH = 5'd15;
    localparam logic [4:0] K_CELL  = 5'd16;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_UNDER   = 3'd1;
    localparam logic [2:0] ERR_OVER    = 3'd2;
    localparam logic [2:0] ERR_DIVZERO = 3'd3;
    localparam logic [2:0] ERR_ADDR    = 3'd4;

    typedef struct packed {
        logic       ready;
        logic       accept;
        logic       decode;
        logic       clr;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       exec;
        logic       arith_start;
        logic       wb_en;
        logic [1:0] wb_slot;
        logic       commit;
        logic       trd;
        logic       tcap;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic early;
        logic need_arith;
        logic arith_done;
        logic out_free;
    } t_sts;

    function automatic logic [1:0] need_of(input logic [4:0] k);
        logic [1:0] n;
        n = 2'd0;
        case (k) inside
            K_ADD, K_SUB, K_MUL, K_DIV, K_2DROP, K_STORE,
            K_SWAP, K_TUCK, K_OVER, K_2DUP: n = 2'd2;
            K_DOT, K_DROP, K_FETCH, K_DUP:  n = 2'd1;
            K_ROT:                          n = 2'd3;
            default:                        n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] grow_of(input logic [4:0] k);
        logic [1:0] g;
        g = 2'd0;
        case (k) inside
            K_LIT, K_CELL, K_DUP, K_TUCK, K_OVER: g = 2'd1;
            K_2DUP:                               g = 2'd2;
            default:                              g = 2'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/forth_data_stack_unit.sv */
// ----------------------------------------------------------------------------
// forth_data_stack_unit: Forth data-stack execution unit
// Runs one word or literal push per beat against a bounded stack of 64-bit
// cells and a local word memory; one result beat per input beat.
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_kind, i_literal
// result    out        o_valid / i_stall  o_error_code, o_emit_valid,
//                                         o_emit_value, o_depth_after,
//                                         o_top_after
//
// A word passes through decode, operand reads, execute, write-back, commit,
// top-of-stack refresh and result delivery; multiply, and divide by a non-zero
// divisor, wait on the serial arithmetic unit; a word rejected at decode skips
// to delivery. After reset the word memory is cleared; o_stall holds meanwhile.
// A stalled result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_data_stack_unit
    import fdsu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MEM_DEPTH   = MEM_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [4:0]    i_kind,
    input  wire logic [DW-1:0] i_literal,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_error_code,
    output logic               o_emit_valid,
    output logic [DW-1:0]      o_emit_value,
    output logic [6:0]         o_depth_after,
    output logic [DW-1:0]      o_top_after
);

    t_cmd cmd;
    t_sts sts;

    fdsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fdsu_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MEM_DEPTH   (MEM_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_literal     (i_literal),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_error_code  (o_error_code),
        .o_emit_valid  (o_emit_valid),
        .o_emit_value  (o_emit_value),
        .o_depth_after (o_depth_after),
        .o_top_after   (o_top_after)
    );

    assign o_stall = !cmd.ready;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a word is in flight");

    a_emit_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_emit_valid) |-> (o_error_code == ERR_OK))
        else $error("emit flagged together with an error");

    a_err_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_code <= ERR_ADDR))
        else $error("error code out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fdsu_arith.sv */
// ----------------------------------------------------------------------------
// fdsu_arith: serial multiply and divide unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_arith
    import fdsu_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_div,
    input  wire logic [DW-1:0] i_x,
    input  wire logic [DW-1:0] i_y,
    output logic               o_done,
    output logic [DW-1:0]      o_result
);

    localparam int SW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic          r_div;
    logic          r_neg;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] n_rem;
    logic          n_qbit;

    always_comb begin
        n_rem  = {r_acc[DW-2:0], r_x[DW-1]};
        n_qbit = (n_rem >= r_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_x[DW-1] ^ i_y[DW-1];
            r_acc <= '0;
            if (i_div) begin
                r_x <= i_x[DW-1] ? (~i_x + DW'(1)) : i_x;
                r_y <= i_y[DW-1] ? (~i_y + DW'(1)) : i_y;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_acc <= n_qbit ? (n_rem - r_y) : n_rem;
                r_x   <= {r_x[DW-2:0], n_qbit};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DW-2:0], 1'b0};
                r_y <= {1'b0, r_y[DW-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (~r_x + DW'(1)) : r_x) : r_acc;

endmodule

`default_nettype wire

/* hw/rtl/fdsu_ctrl.sv */
// ----------------------------------------------------------------------------
// fdsu_ctrl: sequencer for the Forth data-stack unit
// Walks each word through decode, operand reads, execute, write-back, commit,
// top-of-stack refresh and delivery; decode rejects skip to delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_ctrl
    import fdsu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_DECODE = 15'b000000000000100,
        S_RD0    = 15'b000000000001000,
        S_RD1    = 15'b000000000010000,
        S_RD2    = 15'b000000000100000,
        S_EXEC   = 15'b000000001000000,
        S_ARITH  = 15'b000000010000000,
        S_WB0    = 15'b000000100000000,
        S_WB1    = 15'b000001000000000,
        S_WB2    = 15'b000010000000000,
        S_COMMIT = 15'b000100000000000,
        S_TRD    = 15'b001000000000000,
        S_TCAP   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state = i_sts.early ? S_DONE : S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_k  = 2'd0;
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_k  = 2'd1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_k  = 2'd2;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec        = 1'b1;
                o_cmd.arith_start = i_sts.need_arith;
                n_state = i_sts.need_arith ? S_ARITH : S_WB0;
            end
            S_ARITH: begin
                if (i_sts.arith_done) n_state = S_WB0;
            end
            S_WB0: begin
                o_cmd.wb_en   = 1'b1;
                o_cmd.wb_slot = 2'd0;
                n_state = S_WB1;
            end
            S_WB1: begin
                o_cmd.wb_en   = 1'b1;
                o_cmd.wb_slot = 2'd1;
                n_state = S_WB2;
            end
            S_WB2: begin
                o_cmd.wb_en   = 1'b1;
                o_cmd.wb_slot = 2'd2;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_TRD;
            end
            S_TRD: begin
                o_cmd.trd = 1'b1;
                n_state = S_TCAP;
            end
            S_TCAP: begin
                o_cmd.tcap = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.push = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fdsu_dp.sv */
// ----------------------------------------------------------------------------
// fdsu_dp: datapath for the Forth data-stack unit
// Stack memory, word memory, operand registers, arithmetic and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_dp
    import fdsu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MEM_DEPTH   = MEM_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    output t_sts               o_sts,
    input  wire logic [4:0]    i_kind,
    input  wire logic [DW-1:0] i_literal,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [2:0]         o_error_code,
    output logic               o_emit_valid,
    output logic [DW-1:0]      o_emit_value,
    output logic [6:0]         o_depth_after,
    output logic [DW-1:0]      o_top_after
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [DW-1:0] r_sm [STACK_DEPTH];
    logic [DW-1:0] r_wm [MEM_DEPTH];

    logic [4:0]     r_kind;
    logic [DW-1:0]  r_lit;
    logic [CW-1:0]  r_cnt;
    logic [DW-1:0]  r_a;
    logic [DW-1:0]  r_b;
    logic [DW-1:0]  r_c;
    logic [DW-1:0]  r_sm_rd;
    logic [DW-1:0]  r_wm_rd;
    logic           r_ld_en;
    logic [1:0]     r_ld_k;
    logic [DW-1:0]  r_tos;
    logic [2:0]     r_err;
    logic           r_emit;
    logic [MAW-1:0] r_clr_addr;
    logic           r_ovalid;

    logic           n_under;
    logic           n_over;
    logic           n_unknown;
    logic           n_bz;
    logic           n_abad;
    logic [CW-1:0]  n_cnt;
    logic [CW-1:0]  n_rd_pos;
    logic [CW-1:0]  n_wr_pos;
    logic           n_wen;
    logic [DW-1:0]  n_wval;
    logic           arith_done;
    logic [DW-1:0]  arith_res;

    fdsu_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.arith_start),
        .i_div    (r_kind == K_DIV),
        .i_x      (r_b),
        .i_y      (r_a),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    always_comb begin
        n_unknown = (r_kind > K_CELL);
        n_under   = (r_cnt < CW'(need_of(r_kind)));
        n_over    = (({1'b0, r_cnt} + (CW+1)'(grow_of(r_kind))) > (CW+1)'(STACK_DEPTH));
        n_bz      = (r_a == '0);
        n_abad    = r_a[DW-1] || (r_a >= DW'(MEM_DEPTH));
    end

    always_comb begin
        n_cnt = r_cnt;
        unique case (r_kind) inside
            K_LIT, K_CELL, K_DUP, K_TUCK, K_OVER: n_cnt = r_cnt + CW'(1);
            K_2DUP:                               n_cnt = r_cnt + CW'(2);
            K_ADD, K_SUB, K_MUL, K_DOT, K_DROP:   n_cnt = r_cnt - CW'(1);
            K_DIV:   n_cnt = r_cnt - (n_bz ? CW'(2) : CW'(1));
            K_2DROP: n_cnt = r_cnt - CW'(2);
            K_STORE: n_cnt = n_abad ? r_cnt : (r_cnt - CW'(2));
            default: n_cnt = r_cnt;
        endcase
    end

    always_comb begin
        n_wen  = 1'b0;
        n_wval = r_a;
        unique case (r_kind) inside
            K_LIT: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = r_lit;
            end
            K_CELL: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = DW'(CELL_BYTES);
            end
            K_ADD: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = r_b + r_a;
            end
            K_SUB: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = r_b - r_a;
            end
            K_MUL, K_DIV: begin
                n_wen  = (i_cmd.wb_slot == 2'd0) && !((r_kind == K_DIV) && n_bz);
                n_wval = arith_res;
            end
            K_DUP: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = r_a;
            end
            K_OVER: begin
                n_wen  = (i_cmd.wb_slot == 2'd0);
                n_wval = r_b;
            end
            K_SWAP, K_2DUP: begin
                n_wen  = (i_cmd.wb_slot != 2'd2);
                n_wval = (i_cmd.wb_slot == 2'd0) ? ((r_kind == K_SWAP) ? r_b : r_a)
                                                 : ((r_kind == K_SWAP) ? r_a : r_b);
            end
            K_TUCK: begin
                n_wen  = 1'b1;
                n_wval = (i_cmd.wb_slot == 2'd1) ? r_b : r_a;
            end
            K_ROT: begin
                n_wen  = 1'b1;
                n_wval = (i_cmd.wb_slot == 2'd0) ? r_c :
                         (i_cmd.wb_slot == 2'd1) ? r_a : r_b;
            end
            K_FETCH: begin
                n_wen  = (i_cmd.wb_slot == 2'd0) && !n_abad;
                n_wval = r_wm_rd;
            end
            default: begin
                n_wen  = 1'b0;
                n_wval = r_a;
            end
        endcase
    end

    always_comb begin
        n_rd_pos = i_cmd.trd ? (r_cnt - CW'(1))
                             : (r_cnt - CW'(1) - CW'(i_cmd.rd_k));
        n_wr_pos = n_cnt - CW'(1) - CW'(i_cmd.wb_slot);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb_en && n_wen) begin
            r_sm[n_wr_pos[SAW-1:0]] <= n_wval;
        end
        if (i_cmd.rd_en || i_cmd.trd) begin
            r_sm_rd <= r_sm[n_rd_pos[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_wm[r_clr_addr] <= '0;
        end else if (i_cmd.exec && (r_kind == K_STORE) && !n_abad) begin
            r_wm[r_a[MAW-1:0]] <= r_b;
        end
        if (i_cmd.exec) begin
            r_wm_rd <= r_wm[r_a[MAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_lit  <= i_literal;
        end
        if (r_ld_en) begin
            unique case (r_ld_k)
                2'd0:    r_a <= r_sm_rd;
                2'd1:    r_b <= r_sm_rd;
                default: r_c <= r_sm_rd;
            endcase
        end
        if (i_cmd.push) begin
            o_error_code  <= r_err;
            o_emit_valid  <= r_emit;
            o_emit_value  <= r_emit ? r_a : '0;
            o_depth_after <= 7'(r_cnt);
            o_top_after   <= r_tos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_tos      <= '0;
            r_err      <= ERR_OK;
            r_emit     <= 1'b0;
            r_ld_en    <= 1'b0;
            r_ld_k     <= 2'd0;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_ld_en <= i_cmd.rd_en;
            r_ld_k  <= i_cmd.rd_k;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + MAW'(1);
            end
            if (i_cmd.accept) begin
                r_err  <= ERR_OK;
                r_emit <= 1'b0;
            end
            if (i_cmd.decode) begin
                if (n_unknown) begin
                    r_err <= ERR_OK;
                end else if (n_under) begin
                    r_err <= ERR_UNDER;
                end else if (n_over) begin
                    r_err <= ERR_OVER;
                end
            end
            if (i_cmd.exec) begin
                if ((r_kind == K_DIV) && n_bz) begin
                    r_err <= ERR_DIVZERO;
                end else if (((r_kind == K_STORE) || (r_kind == K_FETCH)) && n_abad) begin
                    r_err <= ERR_ADDR;
                end
                r_emit <= (r_kind == K_DOT);
            end
            if (i_cmd.commit) begin
                r_cnt <= n_cnt;
            end
            if (i_cmd.tcap) begin
                r_tos <= (r_cnt == '0) ? '0 : r_sm_rd;
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = (r_clr_addr == MAW'(MEM_DEPTH - 1));
        o_sts.early      = n_unknown || n_under || n_over;
        o_sts.need_arith = (r_kind == K_MUL) || ((r_kind == K_DIV) && !n_bz);
        o_sts.arith_done = arith_done;
        o_sts.out_free   = !r_ovalid || !i_stall;
    end

    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: Forth data-stack unit testbench
// Drives word beats from a queue of pending items, predicts each result with
// a behavioural stack machine, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import fdsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]    kind;
        logic [DW-1:0] literal;
    } t_word;

    typedef struct packed {
        logic [2:0]    error_code;
        logic          emit_valid;
        logic [DW-1:0] emit_value;
        logic [6:0]    depth_after;
        logic [DW-1:0] top_after;
    } t_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [4:0]    i_kind = '0;
    logic [DW-1:0] i_literal = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [2:0]    o_error_code;
    logic          o_emit_valid;
    logic [DW-1:0] o_emit_value;
    logic [6:0]    o_depth_after;
    logic [DW-1:0] o_top_after;

    t_word   pending_words[$];
    t_result expected_results[$];
    int      mismatch_count = 0;
    bit      idle_enable = 1'b1;
    int      hold_off_cycles = 0;
    bit      sender_pause = 1'b0;

    logic [DW-1:0] model_stack[STACK_DEPTH_DEF];
    int            model_count = 0;
    logic [DW-1:0] model_memory[MEM_DEPTH_DEF];

    forth_data_stack_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [DW-1:0] peek(input int from_top);
        return model_stack[model_count - 1 - from_top];
    endfunction

    function automatic void poke(input int from_top, input logic [DW-1:0] v);
        model_stack[model_count - 1 - from_top] = v;
    endfunction

    function automatic logic [DW-1:0] div_trunc(input logic [DW-1:0] a,
                                                 input logic [DW-1:0] b);
        logic [DW-1:0] ma, mb, q;
        ma = a[DW-1] ? -a : a;
        mb = b[DW-1] ? -b : b;
        q = ma / mb;
        return (a[DW-1] != b[DW-1]) ? -q : q;
    endfunction

    function automatic bit addr_fits(input logic [DW-1:0] a);
        return !a[DW-1] && (a < DW'(MEM_DEPTH_DEF));
    endfunction

    function automatic t_result run_word(input t_word w);
        t_result r;
        int need, grow;
        logic [DW-1:0] a, b, c;
        r = '0;
        need = 0;
        grow = 0;
        case (w.kind)
            K_LIT, K_CELL: grow = 1;
            K_ADD, K_SUB, K_MUL, K_DIV, K_2DROP, K_STORE, K_SWAP: need = 2;
            K_DOT, K_DROP, K_FETCH: need = 1;
            K_DUP: begin need = 1; grow = 1; end
            K_TUCK, K_OVER: begin need = 2; grow = 1; end
            K_ROT: need = 3;
            K_2DUP: begin need = 2; grow = 2; end
            default: ;
        endcase
        if (w.kind > K_CELL) begin
        end else if (model_count < need) begin
            r.error_code = ERR_UNDER;
        end else if (model_count + grow > STACK_DEPTH_DEF) begin
            r.error_code = ERR_OVER;
        end else begin
            case (w.kind)
                K_LIT: begin model_count++; poke(0, w.literal); end
                K_CELL: begin model_count++; poke(0, DW'(CELL_BYTES)); end
                K_ADD: begin
                    a = peek(1); b = peek(0); model_count--; poke(0, a + b);
                end
                K_SUB: begin
                    a = peek(1); b = peek(0); model_count--; poke(0, a - b);
                end
                K_MUL: begin
                    a = peek(1); b = peek(0); model_count--; poke(0, a * b);
                end
                K_DIV: begin
                    a = peek(1); b = peek(0);
                    if (b == '0) begin
                        model_count -= 2;
                        r.error_code = ERR_DIVZERO;
                    end else begin
                        model_count--;
                        poke(0, div_trunc(a, b));
                    end
                end
                K_DOT: begin
                    r.emit_value = peek(0); r.emit_valid = 1'b1; model_count--;
                end
                K_DUP: begin a = peek(0); model_count++; poke(0, a); end
                K_DROP: model_count--;
                K_SWAP: begin a = peek(0); b = peek(1); poke(0, b); poke(1, a); end
                K_TUCK: begin
                    a = peek(0); b = peek(1); model_count++;
                    poke(2, a); poke(1, b); poke(0, a);
                end
                K_OVER: begin b = peek(1); model_count++; poke(0, b); end
                K_ROT: begin
                    a = peek(0); b = peek(1); c = peek(2);
                    poke(2, b); poke(1, a); poke(0, c);
                end
                K_2DUP: begin
                    a = peek(0); b = peek(1); model_count += 2;
                    poke(1, b); poke(0, a);
                end
                K_2DROP: model_count -= 2;
                K_STORE: begin
                    a = peek(0); b = peek(1);
                    if (!addr_fits(a)) begin
                        r.error_code = ERR_ADDR;
                    end else begin
                        model_memory[a[7:0]] = b;
                        model_count -= 2;
                    end
                end
                K_FETCH: begin
                    a = peek(0);
                    if (!addr_fits(a)) r.error_code = ERR_ADDR;
                    else poke(0, model_memory[a[7:0]]);
                end
                default: ;
            endcase
        end
        r.depth_after = model_count[6:0];
        r.top_after = (model_count > 0) ? peek(0) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic queue_word(input logic [4:0] k, input logic [DW-1:0] v);
        pending_words.push_back('{kind: k, literal: v});
    endtask

    function automatic logic [DW-1:0] random_value();
        logic [DW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = DW'($urandom_range(0, 300));
            1: v = -DW'($urandom_range(0, 5));
            2: v = {1'b1, 63'd0};
            3: v = {1'b0, {63{1'b1}}};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] random_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return K_LIT;
        if (p < 95) return 5'($urandom_range(K_ADD, K_CELL));
        return 5'($urandom_range(17, 31));
    endfunction

    logic o_stall_q = 1'b1;
    always @(posedge i_clk) o_stall_q <= o_stall;

    // Driver: issue beats at the falling edge
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_valid && !o_stall_q) begin
            if (pending_words.size() > 0 && send_gap == 0 && !sender_pause) begin
                {i_kind, i_literal} <= pending_words.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && pending_words.size() > 0 && send_gap == 0
                     && !sender_pause) begin
            {i_kind, i_literal} <= pending_words.pop_front();
            i_valid <= 1'b1;
        end
        if (send_gap > 0) send_gap--;
        else if (idle_enable && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
    end

    // Accept tracking: predict when the input beat is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(run_word('{kind: i_kind, literal: i_literal}));
        end
    end

    // Receiver stall
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (idle_enable && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 18);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_error_code !== want.error_code)
                    report_mismatch("error_code", o_error_code, want.error_code);
                if (o_emit_valid !== want.emit_valid)
                    report_mismatch("emit_valid", o_emit_valid, want.emit_valid);
                if (o_emit_value !== want.emit_value)
                    report_mismatch("emit_value", o_emit_value, want.emit_value);
                if (o_depth_after !== want.depth_after)
                    report_mismatch("depth_after", o_depth_after, want.depth_after);
                if (o_top_after !== want.top_after)
                    report_mismatch("top_after", o_top_after, want.top_after);
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        bit paused;
        paused = 1'b0;
        for (int i = 0; i < STACK_DEPTH_DEF; i++) model_stack[i] = '0;
        for (int i = 0; i < MEM_DEPTH_DEF; i++) model_memory[i] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: underflow on each word from ADD to ROT, extremes, divide cases, memory edges
        for (int k = K_ADD; k <= K_ROT; k++) queue_word(5'(k), '0);
        queue_word(K_LIT, {1'b1, 63'd0});
        queue_word(K_LIT, '1);
        queue_word(K_DIV, '0);
        queue_word(K_LIT, 64'd7);
        queue_word(K_LIT, '0);
        queue_word(K_DIV, '0);
        queue_word(K_LIT, 64'd5);
        queue_word(K_LIT, 64'd255);
        queue_word(K_STORE, '0);
        queue_word(K_LIT, 64'd255);
        queue_word(K_FETCH, '0);
        queue_word(K_LIT, 64'd256);
        queue_word(K_FETCH, '0);
        queue_word(K_LIT, '1);
        queue_word(K_STORE, '0);
        queue_word(K_CELL, '0);
        queue_word(5'd31, '1);
        wait_drained();

        // Overflow: fill, then the receiver holds off while the sender keeps offering
        hold_off_cycles = 3000;
        for (int i = 0; i < STACK_DEPTH_DEF + 2; i++) queue_word(K_LIT, random_value());
        queue_word(K_2DUP, '0);
        queue_word(K_TUCK, '0);
        queue_word(K_CELL, '0);
        for (int i = 0; i < STACK_DEPTH_DEF; i++) queue_word(K_DOT, '0);
        wait_drained();

        // Random with valid addresses favoured for memory words
        n = 0;
        while (n < 490) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_word(K_LIT, random_value());
                queue_word(K_LIT, $urandom_range(0, 3) == 0 ? random_value()
                                                          : 64'($urandom_range(0, 255)));
                queue_word($urandom_range(0, 1) ? K_STORE : K_FETCH, '0);
                n += 3;
            end else begin
                queue_word(random_kind(), random_value());
                n++;
            end
            if (!paused && n >= 250) begin
                paused = 1'b1;
                wait_drained();
                sender_pause = 1'b1;
                repeat (40) @(posedge i_clk);
                sender_pause = 1'b0;
            end
        end
        while (pending_words.size() > 80) @(posedge i_clk);
        idle_enable = 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/fdsu_pkg.sv
hw/rtl/fdsu_arith.sv
hw/rtl/fdsu_ctrl.sv
hw/rtl/fdsu_dp.sv
hw/rtl/forth_data_stack_unit.sv
bench/tb_top.sv
